[hw/rtl/vlrb_pkg.sv]
// Package: sizes, widths and status codes of the variable-length record ring buffer.
package vlrb_pkg;

  localparam int QUEUE_BYTES = 4096;
  localparam int ADDR_W      = $clog2(QUEUE_BYTES);
  localparam int POS_W       = $clog2(QUEUE_BYTES + 1);
  localparam int LEN_W       = 13;
  localparam int DATA_W      = 8;
  localparam int SUM_W       = (POS_W > LEN_W) ? POS_W + 1 : LEN_W + 1;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [DATA_W-1:0] byte_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

endpackage

[hw/rtl/variable_length_record_ring_buffer_top.sv]
// Top level: byte ring store of whole zero-terminated messages, single-pass pipeline.
// Results: a beat accepted at edge t shows its result (out_valid high)
//   during the following cycle, one result per beat, in order.
// Throughput: one beat per cycle; busy is never raised. The pointer update and the
//   one store access (write or registered read) both fit in the accept cycle.
// Reset (rst_n low, synchronous): pointers to zero, wrap marker to the ring size,
//   no message in progress, no result pending. The store itself is not cleared.
// The receiver cannot stall: each result is on the out_ ports for one cycle only.
module variable_length_record_ring_buffer_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_command,
  input  logic                      in_first_of_message,
  input  logic [vlrb_pkg::LEN_W-1:0] in_message_length,
  input  logic [7:0]                in_data_byte,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [7:0]                out_read_byte,
  output logic                      out_end_of_message
);

  localparam vlrb_pkg::pos_t QB = vlrb_pkg::POS_W'(vlrb_pkg::QUEUE_BYTES);

  // Byte store, no reset; only committed bytes are ever read.
  vlrb_pkg::byte_t store_mem [vlrb_pkg::QUEUE_BYTES];

  // Ring pointers and message-in-progress state.
  vlrb_pkg::pos_t rd_pos_r,  rd_pos_nxt;
  vlrb_pkg::pos_t wr_pos_r,  wr_pos_nxt;
  vlrb_pkg::pos_t wrap_pos_r, wrap_pos_nxt;
  vlrb_pkg::pos_t cur_r,     cur_nxt;
  vlrb_pkg::pos_t rem_r,     rem_nxt;
  logic           adm_r,     adm_nxt;

  // Result stage.
  logic              out_valid_r;
  vlrb_pkg::status_t status_r, status_nxt;
  logic              rd_ok_r,  rd_ok_nxt;
  logic              enq_eom_r, enq_eom_nxt;
  vlrb_pkg::byte_t   rd_data_r;

  // Store port controls.
  logic            mem_we;
  vlrb_pkg::pos_t  mem_waddr;
  vlrb_pkg::byte_t mem_wdata;
  logic            mem_re;

  logic accept;

  // Admission terms for a first byte.
  logic [vlrb_pkg::SUM_W-1:0] wr_ext, rd_ext, len_ext, qb_ext, base_ext;
  vlrb_pkg::pos_t             next_pos;
  logic                       is_full, bad_len, wraps, overlap, wrap_block, refuse;
  vlrb_pkg::pos_t             base;
  vlrb_pkg::pos_t             rd_inc;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    wr_ext   = vlrb_pkg::SUM_W'(wr_pos_r);
    rd_ext   = vlrb_pkg::SUM_W'(rd_pos_r);
    len_ext  = vlrb_pkg::SUM_W'(in_message_length);
    qb_ext   = vlrb_pkg::SUM_W'(vlrb_pkg::QUEUE_BYTES);
    next_pos = (wr_pos_r + 1'b1 >= QB) ? '0 : wr_pos_r + 1'b1;
    is_full  = (next_pos == rd_pos_r);
    bad_len  = (len_ext == '0) || (len_ext > qb_ext);
    wraps    = (wr_ext + len_ext > qb_ext);
    base     = wraps ? '0 : wr_pos_r;
    base_ext = vlrb_pkg::SUM_W'(base);
    overlap  = (base < rd_pos_r) && (base_ext + len_ext >= rd_ext);
    // A wrap may not land on unread data that begins at the ring start.
    wrap_block = wraps && (rd_pos_r == '0) && (rd_pos_r != wr_pos_r);
    refuse     = is_full || bad_len || overlap || wrap_block;
    rd_inc     = rd_pos_r + 1'b1;
  end

  // Next-state and result computation for one beat.
  always_comb begin
    vlrb_pkg::pos_t cur_v;
    vlrb_pkg::pos_t rem_v;
    logic           adm_v;
    vlrb_pkg::status_t st_v;

    rd_pos_nxt   = rd_pos_r;
    wr_pos_nxt   = wr_pos_r;
    wrap_pos_nxt = wrap_pos_r;
    cur_nxt      = cur_r;
    rem_nxt      = rem_r;
    adm_nxt      = adm_r;
    status_nxt   = vlrb_pkg::ST_OK;
    rd_ok_nxt    = 1'b0;
    enq_eom_nxt  = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cur_r;
    mem_wdata    = in_data_byte;
    mem_re       = 1'b0;
    cur_v        = cur_r;
    rem_v        = rem_r;
    adm_v        = adm_r;
    st_v         = vlrb_pkg::ST_OK;

    if (accept) begin
      if (in_command == vlrb_pkg::CMD_ENQ) begin
        if (in_first_of_message) begin
          // Any unfinished message is dropped; judge the new one afresh.
          adm_v = 1'b0;
          rem_v = '0;
          if (refuse) begin
            st_v = vlrb_pkg::ST_NO_ROOM;
          end else begin
            if (wraps) begin
              if (rd_pos_r != wr_pos_r) begin
                wrap_pos_nxt = wr_pos_r;
              end else begin
                wrap_pos_nxt = QB;
                rd_pos_nxt   = '0;
              end
              wr_pos_nxt = '0;
            end
            cur_v = base;
            rem_v = vlrb_pkg::POS_W'(in_message_length);
            adm_v = 1'b1;
          end
        end else if (!adm_r) begin
          st_v = vlrb_pkg::ST_DROPPED;
        end

        if (st_v == vlrb_pkg::ST_OK) begin
          mem_we    = (cur_v < QB);
          mem_waddr = cur_v;
          // Last byte of a message is forced to the terminator.
          mem_wdata = (rem_v == vlrb_pkg::POS_W'(1)) ? '0 : in_data_byte;
          cur_v     = cur_v + 1'b1;
          rem_v     = rem_v - 1'b1;
          if (rem_v == '0) begin
            wr_pos_nxt  = cur_v;
            adm_v       = 1'b0;
            enq_eom_nxt = 1'b1;
          end
        end
        cur_nxt = cur_v;
        rem_nxt = rem_v;
        adm_nxt = adm_v;
      end else begin
        if (rd_pos_r == wr_pos_r) begin
          st_v = vlrb_pkg::ST_EMPTY;
        end else begin
          mem_re    = 1'b1;
          rd_ok_nxt = 1'b1;
          if (rd_inc >= wrap_pos_r) begin
            rd_pos_nxt   = '0;
            wrap_pos_nxt = QB;
            if (wr_pos_r >= QB) begin
              wr_pos_nxt = '0;
            end
          end else begin
            rd_pos_nxt = rd_inc;
          end
        end
      end
    end
    status_nxt = st_v;
  end

  // Store write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr[vlrb_pkg::ADDR_W-1:0]] <= mem_wdata;
    end
  end

  // Store read port, registered.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= store_mem[rd_pos_r[vlrb_pkg::ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pos_r    <= '0;
      wr_pos_r    <= '0;
      wrap_pos_r  <= QB;
      cur_r       <= '0;
      rem_r       <= '0;
      adm_r       <= 1'b0;
      out_valid_r <= 1'b0;
      status_r    <= vlrb_pkg::ST_OK;
      rd_ok_r     <= 1'b0;
      enq_eom_r   <= 1'b0;
    end else begin
      rd_pos_r    <= rd_pos_nxt;
      wr_pos_r    <= wr_pos_nxt;
      wrap_pos_r  <= wrap_pos_nxt;
      cur_r       <= cur_nxt;
      rem_r       <= rem_nxt;
      adm_r       <= adm_nxt;
      out_valid_r <= accept;
      status_r    <= status_nxt;
      rd_ok_r     <= rd_ok_nxt;
      enq_eom_r   <= enq_eom_nxt;
    end
  end

  // Dequeued byte only shows on a successful read; eom marks a zero byte there.
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_read_byte      = rd_ok_r ? rd_data_r : '0;
  assign out_end_of_message = rd_ok_r ? (rd_data_r == '0) : enq_eom_r;

  // One result per accepted beat, next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without accepted beat");

  a_wrap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_pos_r <= QB)
    else $error("wrap marker beyond ring");

  a_adm_owes: assert property (@(posedge clk) disable iff (!rst_n)
    adm_r |-> rem_r != '0)
    else $error("message in progress with nothing owed");

  a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_command == vlrb_pkg::CMD_DEQ && rd_pos_r == wr_pos_r
    |=> $stable(rd_pos_r) && status_r == vlrb_pkg::ST_EMPTY && !out_end_of_message)
    else $error("empty dequeue disturbed state");

endmodule

[dv/tb_top.sv]
// Testbench for the variable-length record ring buffer: driver, monitor, ring predictor.
`timescale 1ns / 100ps

module tb_top;

  // One beat offered to the block, plus the pacing the driver applies to it.
  typedef struct {
    vlrb_pkg::cmd_t             cmd;
    logic                       first;
    logic [vlrb_pkg::LEN_W-1:0] len;
    vlrb_pkg::byte_t            data;
    int                         gap_pct;  // chance per cycle that the driver idles
    bit                         hold;     // wait until every expected result is back
  } ring_beat_t;

  typedef struct {
    vlrb_pkg::status_t status;
    vlrb_pkg::byte_t   rbyte;
    logic              eom;
  } ring_result_t;

  logic                       clk   = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       in_command = 1'b0;
  logic                       in_first_of_message = 1'b0;
  logic [vlrb_pkg::LEN_W-1:0] in_message_length = '0;
  logic [7:0]                 in_data_byte = '0;
  logic                       out_valid;
  logic [1:0]                 out_status;
  logic [7:0]                 out_read_byte;
  logic                       out_end_of_message;

  variable_length_record_ring_buffer_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_command         (in_command),
    .in_first_of_message(in_first_of_message),
    .in_message_length  (in_message_length),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_byte      (out_read_byte),
    .out_end_of_message (out_end_of_message)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Ring predictor state: committed window [rd_pos, wr_pos), wrap marker, and
  // the message currently being received (cursor and bytes still owed).
  // ---------------------------------------------------------------------------
  vlrb_pkg::byte_t            ring_mem [vlrb_pkg::QUEUE_BYTES];
  vlrb_pkg::pos_t             rd_pos;
  vlrb_pkg::pos_t             wr_pos;
  vlrb_pkg::pos_t             wrap_mark;
  vlrb_pkg::pos_t             wr_cur;
  logic [vlrb_pkg::LEN_W-1:0] owed;
  bit                         in_msg;

  ring_beat_t   pending_beats[$];
  ring_result_t expected_results[$];
  ring_beat_t   cur_beat;

  int beats_sent;
  int results_seen;
  int mismatch_count = 0;

  // Generator bookkeeping
  int gen_gap  = 0;
  bit gen_hold = 1'b0;
  int gen_count = 0;

  // Judge a first byte: full, bad length, room, wrap over unread start.
  // On success places the message and may move the wrap marker.
  function automatic vlrb_pkg::status_t admit_message(int len);
    int nxt;
    int base;
    bit wrap;
    nxt = int'(wr_pos) + 1;
    if (nxt >= vlrb_pkg::QUEUE_BYTES) nxt = 0;
    if (nxt == int'(rd_pos)) return vlrb_pkg::ST_NO_ROOM;
    if (len == 0 || len > vlrb_pkg::QUEUE_BYTES) return vlrb_pkg::ST_NO_ROOM;
    if (int'(wr_pos) + len > vlrb_pkg::QUEUE_BYTES) begin
      base = 0;
      wrap = 1'b1;
    end else begin
      base = int'(wr_pos);
      wrap = 1'b0;
    end
    if (base < int'(rd_pos) && base + len >= int'(rd_pos)) return vlrb_pkg::ST_NO_ROOM;
    // unread data sitting at 0 blocks a wrap
    if (wrap && rd_pos == 0 && rd_pos != wr_pos) return vlrb_pkg::ST_NO_ROOM;
    if (wrap) begin
      if (rd_pos != wr_pos) begin
        wrap_mark = wr_pos;
      end else begin
        // empty ring: restart both ends at 0
        wrap_mark = vlrb_pkg::pos_t'(vlrb_pkg::QUEUE_BYTES);
        rd_pos    = '0;
      end
      wr_pos = '0;
    end
    wr_cur = vlrb_pkg::pos_t'(base);
    owed   = vlrb_pkg::LEN_W'(len);
    in_msg = 1'b1;
    return vlrb_pkg::ST_OK;
  endfunction

  function automatic ring_result_t step_ring(ring_beat_t b);
    ring_result_t    r;
    vlrb_pkg::byte_t v;
    r.status = vlrb_pkg::ST_OK;
    r.rbyte  = '0;
    r.eom    = 1'b0;
    if (b.cmd == vlrb_pkg::CMD_ENQ) begin
      if (b.first) begin
        // a new first byte abandons any unfinished message
        in_msg   = 1'b0;
        owed     = '0;
        r.status = admit_message(int'(b.len));
      end else if (!in_msg) begin
        r.status = vlrb_pkg::ST_DROPPED;
      end
      if (r.status == vlrb_pkg::ST_OK) begin
        v = (owed == 1) ? 8'h00 : b.data;  // terminator forced to zero
        if (int'(wr_cur) < vlrb_pkg::QUEUE_BYTES) begin
          ring_mem[wr_cur[vlrb_pkg::ADDR_W-1:0]] = v;
        end
        wr_cur = wr_cur + 1'b1;
        owed   = owed - 1'b1;
        if (owed == 0) begin
          wr_pos = wr_cur;
          in_msg = 1'b0;
          r.eom  = 1'b1;
        end
      end
    end else begin
      if (rd_pos == wr_pos) begin
        r.status = vlrb_pkg::ST_EMPTY;
      end else begin
        v = (int'(rd_pos) < vlrb_pkg::QUEUE_BYTES) ?
            ring_mem[rd_pos[vlrb_pkg::ADDR_W-1:0]] : 8'h00;
        r.rbyte = v;
        r.eom   = (v == 8'h00);
        rd_pos  = rd_pos + 1'b1;
        if (rd_pos >= wrap_mark) begin
          rd_pos    = '0;
          wrap_mark = vlrb_pkg::pos_t'(vlrb_pkg::QUEUE_BYTES);
          if (int'(wr_pos) >= vlrb_pkg::QUEUE_BYTES) wr_pos = '0;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. A beat is taken at an edge with start high and busy low; the
  // predictor runs right there. The next beat is offered at the same edge
  // unless the generator asked for a gap or for a drain. Drain completion is
  // judged from beats sent versus strobes seen, both counted in this block.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start               <= 1'b0;
      in_command          <= 1'b0;
      in_first_of_message <= 1'b0;
      in_message_length   <= '0;
      in_data_byte        <= '0;
      rd_pos       = '0;
      wr_pos       = '0;
      wrap_mark    = vlrb_pkg::pos_t'(vlrb_pkg::QUEUE_BYTES);
      wr_cur       = '0;
      owed         = '0;
      in_msg       = 1'b0;
      beats_sent   = 0;
      results_seen = 0;
    end else begin
      if (out_valid) results_seen++;
      if (start && !busy) begin
        expected_results.push_back(step_ring(cur_beat));
        beats_sent++;
      end
      if (!start || !busy) begin
        if (pending_beats.size() == 0) begin
          start <= 1'b0;
        end else if (pending_beats[0].hold && beats_sent != results_seen) begin
          start <= 1'b0;
        end else if ($urandom_range(0, 99) < pending_beats[0].gap_pct) begin
          start <= 1'b0;
        end else begin
          cur_beat = pending_beats.pop_front();
          start               <= 1'b1;
          in_command          <= cur_beat.cmd;
          in_first_of_message <= cur_beat.first;
          in_message_length   <= cur_beat.len;
          in_data_byte        <= cur_beat.data;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Outputs settle after the rising edge, so the strobe is sampled
  // mid-cycle; one strobe cycle is one result.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    ring_result_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, status %0d byte %0h eom %0b",
                 $time, out_status, out_read_byte, out_end_of_message);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_status);
          mismatch_count++;
        end
        if (out_read_byte !== want.rbyte) begin
          $display("%0t: read_byte expected %0h got %0h", $time, want.rbyte, out_read_byte);
          mismatch_count++;
        end
        if (out_end_of_message !== want.eom) begin
          $display("%0t: end_of_message expected %0b got %0b",
                   $time, want.eom, out_end_of_message);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_beat(vlrb_pkg::cmd_t c, logic f, int len, int d);
    ring_beat_t b;
    b.cmd     = c;
    b.first   = f;
    b.len     = vlrb_pkg::LEN_W'(len);
    b.data    = d[7:0];
    b.gap_pct = gen_gap;
    b.hold    = gen_hold;
    gen_hold  = 1'b0;
    pending_beats.push_back(b);
    gen_count++;
  endtask

  // dequeue; the unused fields carry noise
  task automatic add_read();
    add_beat(vlrb_pkg::CMD_DEQ, 1'($urandom_range(0, 1)), $urandom_range(0, 8191),
             $urandom_range(0, 255));
  endtask

  task automatic add_reads(int n);
    repeat (n) add_read();
  endtask

  // non-first enqueue byte: dropped unless a message is being received
  task automatic add_stray();
    add_beat(vlrb_pkg::CMD_ENQ, 1'b0, $urandom_range(0, 8191), $urandom_range(0, 255));
  endtask

  // Well-formed message of len bytes; 0 < cut < len stops after cut bytes so the
  // next first byte abandons it. Zero bytes inside split it on the read side.
  task automatic add_message(int len, int cut, bit mix_reads);
    int stop;
    int i;
    stop = (cut > 0 && cut < len) ? cut : len;
    add_beat(vlrb_pkg::CMD_ENQ, 1'b1, len, $urandom_range(0, 255));
    for (i = 1; i < stop; i++) begin
      if (mix_reads && $urandom_range(0, 9) == 0) add_read();
      add_beat(vlrb_pkg::CMD_ENQ, 1'b0, $urandom_range(0, 8191),
               ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(0, 255));
    end
  endtask

  // Mixed traffic: mostly whole messages and read bursts, some noise.
  task automatic run_mix(int gap, int n_items);
    int target;
    int r;
    int len;
    gen_gap  = gap;
    gen_hold = 1'b1;  // start the phase from a drained block
    target   = gen_count + n_items;
    while (gen_count < target) begin
      if ($urandom_range(0, 49) == 0) gen_hold = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 50) begin
        r = $urandom_range(0, 99);
        if (r < 80)      len = $urandom_range(1, 48);
        else if (r < 98) len = $urandom_range(49, 400);
        else             len = $urandom_range(401, 640);
        add_message(len, ($urandom_range(0, 11) == 0) ? $urandom_range(1, len) : 0, 1'b1);
      end else if (r < 85) begin
        add_reads($urandom_range(1, 250));
      end else if (r < 93) begin
        repeat ($urandom_range(1, 3)) add_stray();
      end else begin
        add_beat(vlrb_pkg::CMD_ENQ, 1'b1,
                 ($urandom_range(0, 3) == 0) ? 0 :
                 $urandom_range(vlrb_pkg::QUEUE_BYTES + 1, 8191),
                 $urandom_range(0, 255));
        add_stray();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Directed: empty read, stray byte, bad lengths, uncommitted data hidden,
    // abandoned message, forced terminator, embedded zero, wrap over unread.
    gen_gap = 0;
    add_read();                                                 // empty ring
    add_stray();                                                // no message admitted
    add_beat(vlrb_pkg::CMD_ENQ, 1'b1, 0, 8'h12);                // zero length
    add_stray();                                                // byte after a refusal
    add_beat(vlrb_pkg::CMD_ENQ, 1'b1, 8191, 8'hFF);             // length all ones
    add_beat(vlrb_pkg::CMD_ENQ, 1'b1, vlrb_pkg::QUEUE_BYTES + 1, 8'h00);
    add_beat(vlrb_pkg::CMD_ENQ, 1'b1, 4, 8'h01);                // message left unfinished
    add_read();                                                 // nothing committed yet
    add_beat(vlrb_pkg::CMD_ENQ, 1'b0, 0, 8'h7F);
    add_beat(vlrb_pkg::CMD_ENQ, 1'b1, 1, 8'hFF);                // abandons it; forced to 0
    add_beat(vlrb_pkg::CMD_ENQ, 1'b1, 3, 8'hFF);
    add_beat(vlrb_pkg::CMD_ENQ, 1'b0, 0, 8'h00);                // zero inside a message
    add_beat(vlrb_pkg::CMD_ENQ, 1'b0, 8191, 8'h80);             // terminator forced to 0
    add_beat(vlrb_pkg::CMD_ENQ, 1'b1, 2, 8'h55);
    add_beat(vlrb_pkg::CMD_ENQ, 1'b0, 0, 8'hAA);
    add_beat(vlrb_pkg::CMD_ENQ, 1'b1, vlrb_pkg::QUEUE_BYTES, 8'h5A);  // wrap, unread at 0
    add_stray();

    // Paced random phases: no idling, heavy sender idling, light idling.
    run_mix(0, 600);
    run_mix(84, 600);
    run_mix(23, 600);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // All beats taken: checked mid-cycle, where the driver is quiet.
    do @(negedge clk); while (pending_beats.size() != 0 || start);
    // All results back: checked at the edge, where the monitor is quiet.
    do @(posedge clk); while (expected_results.size() != 0);
    // then watch for any extra strobe
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
